FILE: rtl/core/bll_pkg.sv
// Shared constants, types and command structs for the bounded linked list engine.
package bll_pkg;

   localparam int POOL_SLOTS  = 64;
   localparam int VALUE_WIDTH = 32;

   localparam int SLOT_W     = $clog2(POOL_SLOTS);
   localparam int SLOT_CMP_W = SLOT_W + 1;
   localparam int COUNT_W    = $clog2(POOL_SLOTS + 1);

   // Fixed field widths of the stream interface.
   localparam int ITEM_W      = 32;
   localparam int COUNT_FLD_W = 7;
   localparam int REQ_TDATA_W = 32;
   localparam int REQ_TUSER_W = 3;
   localparam int RSP_TDATA_W = 80;
   localparam int RSP_TUSER_W = 2;

   // Request codes.
   localparam logic [REQ_TUSER_W-1:0] OP_INSERT_HEAD = 3'd0;
   localparam logic [REQ_TUSER_W-1:0] OP_INSERT_TAIL = 3'd1;
   localparam logic [REQ_TUSER_W-1:0] OP_SEARCH      = 3'd2;
   localparam logic [REQ_TUSER_W-1:0] OP_REMOVE      = 3'd3;
   localparam logic [REQ_TUSER_W-1:0] OP_CLEAR       = 3'd4;

   // Status codes.
   localparam logic [RSP_TUSER_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [RSP_TUSER_W-1:0] STATUS_EMPTY     = 2'd1;
   localparam logic [RSP_TUSER_W-1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [RSP_TUSER_W-1:0] STATUS_FULL      = 2'd3;

   typedef logic [VALUE_WIDTH-1:0] value_type;
   typedef logic [SLOT_W-1:0]      slot_type;
   typedef logic [COUNT_W-1:0]     count_type;

   // Commands to the slot occupancy map.
   typedef struct packed {
      logic     scan_start;
      logic     scan_step;
      logic     claim;
      logic     drop;
      logic     clear_all;
      slot_type drop_slot;
   } slot_cmd_type;

   // Write commands to the node store.
   typedef struct packed {
      logic      value_we;
      logic      link_we;
      slot_type  wr_slot;
      value_type wr_value;
      slot_type  wr_link;
   } store_cmd_type;

endpackage

FILE: rtl/core/bounded_linked_list_engine_core.sv
// Top level of the bounded linked list engine: request sequencer, list registers and result register.
//
// The engine keeps a singly linked list of values in a pool of POOL_SLOTS node slots and serves
// one request transaction at a time: insert at head, insert at tail, search, remove the first
// match, or clear. Every request transaction yields exactly one result transaction carrying the
// status, the found flag, the element count and the head and tail values. A request's length is
// set by the shared node store read port and the free-slot scan: an insert scans upward from
// slot zero to the lowest free slot (a tail insert then patches the old tail's link); a search
// or remove walks the nodes with one compare per memory read, and a removal of the head adds a
// step to read the new head's value; a clear or an unknown code goes straight to the result.
// A finished result sits in an output register, so the next request transaction is taken while
// it still waits.
module bounded_linked_list_engine_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // req_tdata: item_value [31:0]
   input  logic [bll_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // req_tuser: req_type [2:0]
   input  logic [bll_pkg::REQ_TUSER_W-1:0]   req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // rsp_tdata: found [0], element_count [7:1], is_empty [8], first_value [40:9],
   // last_value [72:41], zero padding [79:73]
   output logic [bll_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // rsp_tuser: status [1:0]
   output logic [bll_pkg::RSP_TUSER_W-1:0]   rsp_tuser
);
   import bll_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE      = 7'b0000001,
      S_DISPATCH  = 7'b0000010,
      S_SCAN      = 7'b0000100,
      S_LINK      = 7'b0001000,
      S_WALK      = 7'b0010000,
      S_HEAD_FIX  = 7'b0100000,
      S_DONE      = 7'b1000000
   } state_type;

   // A link that points outside the pool is treated as slot zero.
   function automatic slot_type next_of(input slot_type link);
      next_of = (SLOT_CMP_W'(link) < SLOT_CMP_W'(POOL_SLOTS)) ? link : '0;
   endfunction

   state_type                  state_ff, state_in;
   logic [REQ_TUSER_W-1:0]     op_ff, op_in;
   value_type                  value_ff, value_in;
   slot_type                   head_ff, head_in;
   slot_type                   tail_ff, tail_in;
   count_type                  count_ff, count_in;
   value_type                  head_val_ff, head_val_in;
   value_type                  tail_val_ff, tail_val_in;
   slot_type                   cur_ff, cur_in;
   slot_type                   prev_ff, prev_in;
   value_type                  prev_val_ff, prev_val_in;
   count_type                  walk_ff, walk_in;
   slot_type                   new_slot_ff, new_slot_in;
   logic [RSP_TUSER_W-1:0]     status_ff, status_in;
   logic                       found_ff, found_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0]     rsp_data_ff, rsp_data_in;
   logic [RSP_TUSER_W-1:0]     rsp_user_ff, rsp_user_in;

   slot_cmd_type               slot_cmd;
   store_cmd_type              store_cmd;
   slot_type                   rd_slot;
   value_type                  rd_value;
   slot_type                   rd_link;
   logic                       scan_free;
   slot_type                   scan_slot;
   slot_type                   next_slot;
   logic                       value_hit;
   logic                       list_empty;
   logic [ITEM_W-1:0]          first_out;
   logic [ITEM_W-1:0]          last_out;

   bll_slot_map u_slot_map (
      .clock     (clock),
      .reset     (reset),
      .cmd       (slot_cmd),
      .scan_free (scan_free),
      .scan_slot (scan_slot)
   );

   bll_node_store u_node_store (
      .clock    (clock),
      .cmd      (store_cmd),
      .rd_slot  (rd_slot),
      .rd_value (rd_value),
      .rd_link  (rd_link)
   );

   // The one comparator that the walk shares across every visited node.
   assign value_hit = (rd_value == value_ff);
   assign next_slot = next_of(rd_link);

   assign list_empty = (count_ff == '0);
   assign first_out  = list_empty ? '0 : ITEM_W'(head_val_ff);
   assign last_out   = list_empty ? '0 : ITEM_W'(tail_val_ff);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      value_in     = value_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      head_val_in  = head_val_ff;
      tail_val_in  = tail_val_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      prev_val_in  = prev_val_ff;
      walk_in      = walk_ff;
      new_slot_in  = new_slot_ff;
      status_in    = status_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      slot_cmd     = '0;
      store_cmd    = '0;
      rd_slot      = cur_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tuser;
               // Sign-extend or truncate the item to the stored value width.
               value_in = VALUE_WIDTH'($signed(req_tdata[ITEM_W-1:0]));
               state_in = S_DISPATCH;
            end
         end

         S_DISPATCH: begin
            status_in = STATUS_OK;
            found_in  = 1'b0;
            rd_slot   = head_ff;
            case (op_ff)
               OP_INSERT_HEAD, OP_INSERT_TAIL: begin
                  if (count_ff >= COUNT_W'(POOL_SLOTS)) begin
                     status_in = STATUS_FULL;
                     state_in  = S_DONE;
                  end else begin
                     slot_cmd.scan_start = 1'b1;
                     state_in            = S_SCAN;
                  end
               end
               OP_SEARCH, OP_REMOVE: begin
                  if (list_empty) begin
                     status_in = STATUS_EMPTY;
                     state_in  = S_DONE;
                  end else begin
                     // The head read is issued now; its data arrives in the first walk cycle.
                     cur_in   = head_ff;
                     prev_in  = head_ff;
                     walk_in  = '0;
                     state_in = S_WALK;
                  end
               end
               OP_CLEAR: begin
                  slot_cmd.clear_all = 1'b1;
                  head_in            = '0;
                  tail_in            = '0;
                  count_in           = '0;
                  state_in           = S_DONE;
               end
               default: begin
                  // Unknown request codes leave the list alone.
                  state_in = S_DONE;
               end
            endcase
         end

         S_SCAN: begin
            if (scan_free) begin
               slot_cmd.claim     = 1'b1;
               store_cmd.value_we = 1'b1;
               store_cmd.link_we  = 1'b1;
               store_cmd.wr_slot  = scan_slot;
               store_cmd.wr_value = value_ff;
               store_cmd.wr_link  = (!list_empty && op_ff == OP_INSERT_HEAD) ? head_ff : '0;
               count_in           = count_ff + 1'b1;
               if (list_empty) begin
                  head_in     = scan_slot;
                  tail_in     = scan_slot;
                  head_val_in = value_ff;
                  tail_val_in = value_ff;
                  state_in    = S_DONE;
               end else if (op_ff == OP_INSERT_HEAD) begin
                  head_in     = scan_slot;
                  head_val_in = value_ff;
                  state_in    = S_DONE;
               end else begin
                  new_slot_in = scan_slot;
                  state_in    = S_LINK;
               end
            end else begin
               slot_cmd.scan_step = 1'b1;
            end
         end

         S_LINK: begin
            // The old tail now points at the new node.
            store_cmd.link_we = 1'b1;
            store_cmd.wr_slot = tail_ff;
            store_cmd.wr_link = new_slot_ff;
            tail_in           = new_slot_ff;
            tail_val_in       = value_ff;
            state_in          = S_DONE;
         end

         S_WALK: begin
            // The next node's read goes out every cycle; it is used only if the walk goes on
            // or the removed node was the head.
            rd_slot = next_slot;
            if (value_hit) begin
               found_in = 1'b1;
               state_in = S_DONE;
               if (op_ff == OP_REMOVE) begin
                  slot_cmd.drop      = 1'b1;
                  slot_cmd.drop_slot = cur_ff;
                  count_in           = count_ff - 1'b1;
                  if (count_ff == count_type'(1)) begin
                     head_in = '0;
                     tail_in = '0;
                  end else begin
                     if (cur_ff == tail_ff) begin
                        tail_in     = prev_ff;
                        tail_val_in = prev_val_ff;
                     end
                     if (cur_ff == head_ff) begin
                        head_in  = next_slot;
                        state_in = S_HEAD_FIX;
                     end else begin
                        store_cmd.link_we = 1'b1;
                        store_cmd.wr_slot = prev_ff;
                        store_cmd.wr_link = next_slot;
                     end
                  end
               end
            end else if (count_type'(walk_ff + 1'b1) == count_ff) begin
               status_in = STATUS_NOT_FOUND;
               state_in  = S_DONE;
            end else begin
               prev_in     = cur_ff;
               prev_val_in = rd_value;
               cur_in      = next_slot;
               walk_in     = walk_ff + 1'b1;
            end
         end

         S_HEAD_FIX: begin
            // The new head's value was read in the previous cycle.
            head_val_in = rd_value;
            state_in    = S_DONE;
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = status_ff;
               rsp_data_in  = {(RSP_TDATA_W - 73)'(0), last_out, first_out, list_empty,
                               COUNT_FLD_W'(count_ff), found_ff};
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      value_ff    <= value_in;
      head_val_ff <= head_val_in;
      tail_val_ff <= tail_val_in;
      cur_ff      <= cur_in;
      prev_ff     <= prev_in;
      prev_val_ff <= prev_val_in;
      walk_ff     <= walk_in;
      new_slot_ff <= new_slot_in;
      status_ff   <= status_in;
      found_ff    <= found_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

FILE: rtl/core/bll_node_store.sv
// Node value and link memories with one write port and one registered read port.
module bll_node_store (
   input  logic                    clock,
   input  bll_pkg::store_cmd_type  cmd,
   input  bll_pkg::slot_type       rd_slot,
   output bll_pkg::value_type      rd_value,
   output bll_pkg::slot_type       rd_link
);
   import bll_pkg::*;

   value_type value_mem [POOL_SLOTS];
   slot_type  link_mem  [POOL_SLOTS];
   value_type rd_value_ff;
   slot_type  rd_link_ff;

   always_ff @(posedge clock) begin
      if (cmd.value_we) begin
         value_mem[cmd.wr_slot] <= cmd.wr_value;
      end
      rd_value_ff <= value_mem[rd_slot];
   end

   always_ff @(posedge clock) begin
      if (cmd.link_we) begin
         link_mem[cmd.wr_slot] <= cmd.wr_link;
      end
      rd_link_ff <= link_mem[rd_slot];
   end

   assign rd_value = rd_value_ff;
   assign rd_link  = rd_link_ff;

endmodule

FILE: rtl/core/bll_slot_map.sv
// Slot occupancy bits and the free-slot scan pointer that looks for the lowest free slot.
module bll_slot_map (
   input  logic                  clock,
   input  logic                  reset,
   input  bll_pkg::slot_cmd_type cmd,
   output logic                  scan_free,
   output bll_pkg::slot_type     scan_slot
);
   import bll_pkg::*;

   logic [POOL_SLOTS-1:0] used_ff, used_in;
   slot_type              ptr_ff, ptr_in;

   always_comb begin
      used_in = used_ff;
      ptr_in  = ptr_ff;
      if (cmd.clear_all) begin
         used_in = '0;
      end else begin
         if (cmd.claim) begin
            used_in[ptr_ff] = 1'b1;
         end
         if (cmd.drop) begin
            used_in[cmd.drop_slot] = 1'b0;
         end
      end
      if (cmd.scan_start) begin
         ptr_in = '0;
      end else if (cmd.scan_step) begin
         ptr_in = ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         ptr_ff  <= '0;
      end else begin
         used_ff <= used_in;
         ptr_ff  <= ptr_in;
      end
   end

   assign scan_free = ~used_ff[ptr_ff];
   assign scan_slot = ptr_ff;

endmodule

FILE: rtl/core/bll_checker.sv
// Port-level checker for the bounded linked list engine, bound to its top level.
module bll_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [bll_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input logic [bll_pkg::RSP_TUSER_W-1:0]   rsp_tuser
);
   import bll_pkg::*;

   // A stalled result transaction holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // One request at a time: the engine is busy in the cycle after it takes a request.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while a request was in progress");

   // A full status only ever reports a full pool.
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STATUS_FULL |-> rsp_tdata[7:1] == COUNT_FLD_W'(POOL_SLOTS))
      else $error("full status with a pool that is not full");

   // The empty flag follows the count, and an empty list shows zero head and tail values.
   a_empty_view: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[8] == (rsp_tdata[7:1] == '0)) &&
                     (!rsp_tdata[8] || (rsp_tdata[40:9] == '0 && rsp_tdata[72:41] == '0)))
      else $error("empty flag, count and end values disagree");

endmodule

bind bounded_linked_list_engine_core bll_checker u_bll_checker (.*);
